// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file esne_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ESNE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ESNE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/esne_pkg.sv =====
// ----------------------------------------------------------------------------
// esne_pkg
// Types and constants of the edge set neighbour enumerator.
// ----------------------------------------------------------------------------
`default_nettype none

package esne_pkg;

    localparam int NUM_OBJECTS = 5;
    localparam int REL_COUNT   = NUM_OBJECTS * (NUM_OBJECTS - 1) / 2;
    localparam int REL_W       = 10;
    localparam logic [REL_W-1:0] REL_MASK = REL_W'((1 << REL_COUNT) - 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_REMOVE_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_ENABLE   = 1'd1;

    typedef enum logic [1:0] {
        KIND_REMOVE = 2'd0,
        KIND_ADD    = 2'd1,
        KIND_SWAP   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_ADD,
        ST_SWAP
    } t_state;

    typedef struct packed {
        logic  load;
        logic  emit;
        t_kind kind;
    } t_ctrl;

    typedef struct packed {
        logic rem_en;
        logic swap_en;
        logic cur_any;
        logic rem_any;
        logic rem_one;
        logic zrem_any;
        logic srem_any;
        logic srem_one;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== sv/esne_datapath.sv =====
// ----------------------------------------------------------------------------
// esne_datapath
// Holds the edge set, the pending-bit masks, the config and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module esne_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [esne_pkg::REL_W-1:0]        i_relation_bits,
    input  wire logic                              i_cfg_we,
    input  wire logic [esne_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [esne_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_out_stall,
    input  wire esne_pkg::t_ctrl                   i_ctrl,
    output esne_pkg::t_stat                        o_stat,
    output logic                                   o_out_valid,
    output logic [esne_pkg::REL_W-1:0]             o_neighbour_bits,
    output esne_pkg::t_kind                        o_move_kind,
    output logic                                   o_last_of_run
);
    import esne_pkg::*;

    logic [REL_W-1:0] r_cur;
    logic [REL_W-1:0] r_rem;
    logic [REL_W-1:0] r_zrem;
    logic [REL_W-1:0] r_srem;
    logic [REL_W-1:0] r_zbit;
    logic             r_rem_en;
    logic             r_swap_en;
    logic             r_out_valid;
    logic [REL_W-1:0] r_out_bits;
    t_kind            r_out_kind;
    logic             r_out_last;

    logic [REL_W-1:0] cur_in;
    logic [REL_W-1:0] rem_low;
    logic [REL_W-1:0] zrem_low;
    logic [REL_W-1:0] srem_low;
    logic [REL_W-1:0] n_out_bits;
    logic             n_out_last;

    assign cur_in   = i_relation_bits & REL_MASK;
    assign rem_low  = r_rem & (~r_rem + 1'b1);
    assign zrem_low = r_zrem & (~r_zrem + 1'b1);
    assign srem_low = r_srem & (~r_srem + 1'b1);

    always_comb begin
        case (i_ctrl.kind)
            KIND_REMOVE: begin
                n_out_bits = r_cur & ~rem_low;
                n_out_last = ((r_rem & ~rem_low) == '0) && (r_zrem == '0);
            end
            KIND_ADD: begin
                n_out_bits = r_cur | zrem_low;
                n_out_last = !(r_swap_en && (r_cur != '0))
                             && ((r_zrem & ~zrem_low) == '0);
            end
            KIND_SWAP: begin
                n_out_bits = (r_cur | r_zbit) & ~srem_low;
                n_out_last = ((r_srem & ~srem_low) == '0) && (r_zrem == '0);
            end
            default: begin
                n_out_bits = '0;
                n_out_last = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem_en    <= 1'b1;
            r_swap_en   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_REMOVE_ENABLE: r_rem_en  <= i_cfg_data[0];
                    CFG_SWAP_ENABLE:   r_swap_en <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_ctrl.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cur  <= cur_in;
            r_rem  <= cur_in;
            r_zrem <= ~cur_in & REL_MASK;
        end
        if (i_ctrl.emit) begin
            r_out_bits <= n_out_bits;
            r_out_kind <= i_ctrl.kind;
            r_out_last <= n_out_last;
            case (i_ctrl.kind)
                KIND_REMOVE: r_rem <= r_rem & ~rem_low;
                KIND_ADD: begin
                    r_zrem <= r_zrem & ~zrem_low;
                    r_zbit <= zrem_low;
                    r_srem <= r_cur;
                end
                KIND_SWAP: r_srem <= r_srem & ~srem_low;
                default: ;
            endcase
        end
    end

    assign o_stat.rem_en   = r_rem_en;
    assign o_stat.swap_en  = r_swap_en;
    assign o_stat.cur_any  = (r_cur != '0);
    assign o_stat.rem_any  = (r_rem != '0);
    assign o_stat.rem_one  = (r_rem == rem_low);
    assign o_stat.zrem_any = (r_zrem != '0);
    assign o_stat.srem_any = (r_srem != '0);
    assign o_stat.srem_one = (r_srem == srem_low);
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid      = r_out_valid;
    assign o_neighbour_bits = r_out_bits;
    assign o_move_kind      = r_out_kind;
    assign o_last_of_run    = r_out_last;

endmodule

`default_nettype wire

// ===== sv/esne_ctrl.sv =====
// ----------------------------------------------------------------------------
// esne_ctrl
// Phase sequencer: removes, then each add followed by its swaps.
// ----------------------------------------------------------------------------
`default_nettype none

module esne_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire esne_pkg::t_stat i_stat,
    output esne_pkg::t_ctrl      o_ctrl
);
    import esne_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_ctrl.load = 1'b0;
        o_ctrl.emit = 1'b0;
        o_ctrl.kind = KIND_REMOVE;
        o_in_stall  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_ctrl.load = 1'b1;
                    n_state     = i_stat.rem_en ? ST_REMOVE : ST_ADD;
                end
            end
            ST_REMOVE: begin
                o_ctrl.kind = KIND_REMOVE;
                if (!i_stat.rem_any) begin
                    n_state = ST_ADD;
                end else if (i_stat.out_free) begin
                    o_ctrl.emit = 1'b1;
                    if (i_stat.rem_one) begin
                        n_state = ST_ADD;
                    end
                end
            end
            ST_ADD: begin
                o_ctrl.kind = KIND_ADD;
                if (!i_stat.zrem_any) begin
                    n_state = ST_IDLE;
                end else if (i_stat.out_free) begin
                    o_ctrl.emit = 1'b1;
                    if (i_stat.swap_en && i_stat.cur_any) begin
                        n_state = ST_SWAP;
                    end
                end
            end
            ST_SWAP: begin
                o_ctrl.kind = KIND_SWAP;
                if (!i_stat.srem_any) begin
                    n_state = ST_ADD;
                end else if (i_stat.out_free) begin
                    o_ctrl.emit = 1'b1;
                    if (i_stat.srem_one) begin
                        n_state = ST_ADD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/edge_set_neighbour_enumerator.sv =====
// ----------------------------------------------------------------------------
// edge_set_neighbour_enumerator
// Emits the remove, add and swap neighbours of a relation bit vector.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        input      i_in_valid/o_in_stall  i_relation_bits
//  out       output     o_out_valid/i_out_stall o_neighbour_bits, o_move_kind,
//                                              o_last_of_run
//  cfg       input      i_cfg_we               i_cfg_index, i_cfg_data
//
//  While the output register is free, the sequencer emits one result per
//  cycle into a single output register.
//  An item with no neighbours emits nothing.
//  Synchronous active-low reset; remove and swap are enabled after reset.
//  An output stall holds the sequencer; the next item is taken while the
//  last result of the previous one still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module edge_set_neighbour_enumerator (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [esne_pkg::REL_W-1:0]        i_relation_bits,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [esne_pkg::REL_W-1:0]             o_neighbour_bits,
    output logic [1:0]                             o_move_kind,
    output logic                                   o_last_of_run,
    input  wire logic                              i_cfg_we,
    input  wire logic [esne_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [esne_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import esne_pkg::*;

    t_ctrl ctrl;
    t_stat stat;
    t_kind move_kind;

    esne_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    esne_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_relation_bits  (i_relation_bits),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_out_stall      (i_out_stall),
        .i_ctrl           (ctrl),
        .o_stat           (stat),
        .o_out_valid      (o_out_valid),
        .o_neighbour_bits (o_neighbour_bits),
        .o_move_kind      (move_kind),
        .o_last_of_run    (o_last_of_run)
    );

    assign o_move_kind = move_kind;

endmodule

`default_nettype wire

// ===== sv/esne_chk.sv =====
// ----------------------------------------------------------------------------
// esne_chk
// Port-level checks of the neighbour enumerator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module esne_chk (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       o_in_stall,
    input  wire logic       o_out_valid,
    input  wire logic       i_out_stall,
    input  wire logic [9:0] o_neighbour_bits,
    input  wire logic [1:0] o_move_kind,
    input  wire logic       o_last_of_run
);

    `ESNE_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !o_out_valid, "out valid after reset")

    `ESNE_ASSERT(a_stall_holds, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_neighbour_bits) && $stable(o_move_kind) && $stable(o_last_of_run), "stalled item changed")

    `ESNE_ASSERT(a_busy_mid_run, o_out_valid && !o_last_of_run |-> o_in_stall, "input open mid run")

    `ESNE_ASSERT(a_kind_legal, o_out_valid |-> o_move_kind != 2'd3, "bad move kind")

endmodule

bind edge_set_neighbour_enumerator esne_chk u_esne_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_neighbour_bits (o_neighbour_bits),
    .o_move_kind      (o_move_kind),
    .o_last_of_run    (o_last_of_run)
);

`default_nettype wire
